### sv/lpps_pkg.sv
// ----------------------------------------------------------------------------
// lpps_pkg: shared types, constants and microcode for the line steering block
// Payload structs, register indexes, control word format and the program ROM.
// ----------------------------------------------------------------------------
package lpps_pkg;

   localparam int SENSOR_COUNT     = 5;
   localparam int WEIGHT_SCALE_DEF = 1000;
   localparam int SENSOR_W         = 10;
   localparam int GAIN_W           = 8;
   localparam int SPEED_CFG_W      = 10;
   localparam int SPEED_W          = 12;
   localparam int Q_FRAC           = 8;

   localparam int SENSOR_MAX = (1 << SENSOR_W) - 1;
   localparam int VSUM_W     = $clog2(SENSOR_COUNT * SENSOR_MAX + 1);
   localparam int WIDX_MAX   = SENSOR_MAX * (SENSOR_COUNT * (SENSOR_COUNT - 1) / 2);
   localparam int WIDX_W     = $clog2(WIDX_MAX + 1);

   localparam int DIV_STEP_BITS = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_NUM       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_DEN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_NUM      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_DEN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_THRESHOLD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_FACTOR   = 3'd6;

   typedef struct packed {
      logic [SENSOR_W-1:0] sensor_0;
      logic [SENSOR_W-1:0] sensor_1;
      logic [SENSOR_W-1:0] sensor_2;
      logic [SENSOR_W-1:0] sensor_3;
      logic [SENSOR_W-1:0] sensor_4;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] left_speed;
      logic [SPEED_W-1:0] right_speed;
      logic               line_found;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_SUM,
      OP_WMUL,
      OP_DIV,
      OP_LOAD_POS,
      OP_ERR,
      OP_PMUL,
      OP_LOAD_P,
      OP_DMUL,
      OP_LOAD_D,
      OP_CLAMP,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_REQ,
      WAIT_DIV,
      WAIT_OUT
   } wait_type;

   typedef enum logic [1:0] {
      BR_NONE,
      BR_ALWAYS,
      BR_NO_LINE
   } br_type;

   localparam int PC_W = 4;

   localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
   localparam logic [PC_W-1:0] PC_SUM  = 4'd1;
   localparam logic [PC_W-1:0] PC_ERR  = 4'd5;
   localparam logic [PC_W-1:0] PC_EMIT = 4'd13;

   typedef struct packed {
      op_type          op;
      wait_type        wt;
      br_type          br;
      logic [PC_W-1:0] target;
   } ucode_type;

   function automatic ucode_type mk_uc(input op_type op, input wait_type wt,
                                       input br_type br, input logic [PC_W-1:0] target);
      ucode_type w;
      w.op     = op;
      w.wt     = wt;
      w.br     = br;
      w.target = target;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         4'd0:    w = mk_uc(OP_CAPTURE,  WAIT_REQ,  BR_NONE,    PC_IDLE);
         4'd1:    w = mk_uc(OP_SUM,      WAIT_NONE, BR_NONE,    PC_IDLE);
         4'd2:    w = mk_uc(OP_WMUL,     WAIT_NONE, BR_NO_LINE, PC_ERR);
         4'd3:    w = mk_uc(OP_DIV,      WAIT_NONE, BR_NONE,    PC_IDLE);
         4'd4:    w = mk_uc(OP_LOAD_POS, WAIT_DIV,  BR_NONE,    PC_IDLE);
         4'd5:    w = mk_uc(OP_ERR,      WAIT_NONE, BR_NONE,    PC_IDLE);
         4'd6:    w = mk_uc(OP_PMUL,     WAIT_NONE, BR_NONE,    PC_IDLE);
         4'd7:    w = mk_uc(OP_DIV,      WAIT_NONE, BR_NONE,    PC_IDLE);
         4'd8:    w = mk_uc(OP_LOAD_P,   WAIT_DIV,  BR_NONE,    PC_IDLE);
         4'd9:    w = mk_uc(OP_DMUL,     WAIT_NONE, BR_NONE,    PC_IDLE);
         4'd10:   w = mk_uc(OP_DIV,      WAIT_NONE, BR_NONE,    PC_IDLE);
         4'd11:   w = mk_uc(OP_LOAD_D,   WAIT_DIV,  BR_NONE,    PC_IDLE);
         4'd12:   w = mk_uc(OP_CLAMP,    WAIT_NONE, BR_NONE,    PC_IDLE);
         4'd13:   w = mk_uc(OP_EMIT,     WAIT_OUT,  BR_ALWAYS,  PC_IDLE);
         default: w = mk_uc(OP_NOP,      WAIT_NONE, BR_ALWAYS,  PC_IDLE);
      endcase
      return w;
   endfunction

endpackage

### sv/line_position_pd_steering.sv
// ----------------------------------------------------------------------------
// line_position_pd_steering: line centroid and PD wheel steering
// Microcoded sequencer over a small datapath with a shared iterative divider.
// ----------------------------------------------------------------------------
//  port group | role                  | handshake          | payload
//  req_       | sensor frame in       | req_valid/req_stall | req_type
//  rsp_       | wheel speeds out      | rsp_valid/rsp_stall | rsp_type
//  csr_       | register write        | csr_we             | csr_index, csr_wdata
//
//  One frame at a time: a frame with a line seen makes three divides on the
//  shared divider, a frame without makes two. Reset returns the program
//  counter to idle, loads the register defaults and clears the held position,
//  last error and output valid.
//  A stalled result holds in the output register; the next frame is accepted
//  while it waits, and the program holds at its last step until it drains.
// ----------------------------------------------------------------------------
module line_position_pd_steering
   import lpps_pkg::*;
#(
   parameter int WEIGHT_SCALE = WEIGHT_SCALE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int POS_MAX = (SENSOR_COUNT - 1) * WEIGHT_SCALE;
   localparam int CENTRE  = POS_MAX / 2;
   localparam int POS_W   = $clog2(POS_MAX + 1);
   localparam int ERR_W   = POS_W + 1;
   localparam int MAG_W   = POS_W + GAIN_W;
   localparam int WSUM_W  = $clog2(WIDX_MAX * WEIGHT_SCALE + 1);
   localparam int DVD_W   = (WSUM_W > MAG_W) ? WSUM_W : MAG_W;
   localparam int TERM_W  = MAG_W + 2;
   localparam int WHEEL_W = TERM_W + 1;
   localparam int PROD_W  = 2 * SPEED_CFG_W;

   function automatic logic [POS_W-1:0] mag_of(input logic signed [ERR_W-1:0] x);
      logic signed [ERR_W-1:0] n;
      n = -x;
      return x[ERR_W-1] ? n[POS_W-1:0] : x[POS_W-1:0];
   endfunction

   function automatic logic [GAIN_W-1:0] den_fix(input logic [GAIN_W-1:0] d);
      return (d == '0) ? GAIN_W'(1) : d;
   endfunction

   function automatic logic [SPEED_CFG_W-1:0] clamp_speed(
      input logic signed [WHEEL_W-1:0] v, input logic [SPEED_CFG_W-1:0] top);
      logic signed [WHEEL_W-1:0] m;
      m = $signed(WHEEL_W'(top));
      if (v < 0) begin
         return '0;
      end else if (v > m) begin
         return top;
      end else begin
         return v[SPEED_CFG_W-1:0];
      end
   endfunction

   // configuration
   logic [GAIN_W-1:0]      prop_num_ff, prop_num_in;
   logic [GAIN_W-1:0]      prop_den_ff, prop_den_in;
   logic [GAIN_W-1:0]      deriv_num_ff, deriv_num_in;
   logic [GAIN_W-1:0]      deriv_den_ff, deriv_den_in;
   logic [SPEED_CFG_W-1:0] max_speed_ff, max_speed_in;
   logic [SENSOR_W-1:0]    line_threshold_ff, line_threshold_in;
   logic [SPEED_CFG_W-1:0] speed_factor_ff, speed_factor_in;

   // sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       uc_word;
   logic            wait_on;
   logic            step_go;
   logic            br_take;

   // datapath
   req_type                   req_ff, req_in;
   logic [SENSOR_W-1:0]       sens [SENSOR_COUNT];
   logic [VSUM_W-1:0]         sum_v;
   logic [WIDX_W-1:0]         sum_w;
   logic                      any_hit;
   logic [VSUM_W-1:0]         vsum_ff, vsum_in;
   logic [WIDX_W-1:0]         widx_ff, widx_in;
   logic                      found_ff, found_in;
   logic [WSUM_W-1:0]         wsum;
   logic [DVD_W-1:0]          prod_ff, prod_in;
   logic [VSUM_W-1:0]         dvs_ff, dvs_in;
   logic                      sign_ff, sign_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   ediff_ff, ediff_in;
   logic signed [ERR_W-1:0]   err_now;
   logic signed [ERR_W-1:0]   ediff_now;
   logic signed [TERM_W-1:0]  pterm_ff, pterm_in;
   logic signed [TERM_W-1:0]  diff_ff, diff_in;
   logic signed [TERM_W-1:0]  qs;
   logic [MAG_W-1:0]          q_mag;
   logic signed [WHEEL_W-1:0] lv;
   logic signed [WHEEL_W-1:0] rv;
   logic [SPEED_CFG_W-1:0]    lclamp_ff, lclamp_in;
   logic [SPEED_CFG_W-1:0]    rclamp_ff, rclamp_in;
   logic [PROD_W-1:0]         lprod;
   logic [PROD_W-1:0]         rprod;
   logic                      emit_go;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // divider
   logic             div_start;
   logic             div_busy;
   logic [DVD_W-1:0] div_quo;

   lpps_div #(
      .DVD_W     (DVD_W),
      .DVS_W     (VSUM_W),
      .STEP_BITS (DIV_STEP_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (dvs_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // sequencer
   assign uc_word = ucode_rom(pc_ff);

   always_comb begin
      case (uc_word.wt)
         WAIT_REQ: wait_on = !req_valid;
         WAIT_DIV: wait_on = div_busy;
         WAIT_OUT: wait_on = rsp_valid_ff && rsp_stall;
         default:  wait_on = 1'b0;
      endcase
      case (uc_word.br)
         BR_ALWAYS:  br_take = 1'b1;
         BR_NO_LINE: br_take = !found_ff;
         default:    br_take = 1'b0;
      endcase
   end

   assign step_go = !wait_on;
   assign pc_in   = wait_on ? pc_ff : (br_take ? uc_word.target : pc_ff + 1'b1);

   assign req_stall = (pc_ff != PC_IDLE);

   // configuration writes
   always_comb begin
      prop_num_in       = prop_num_ff;
      prop_den_in       = prop_den_ff;
      deriv_num_in      = deriv_num_ff;
      deriv_den_in      = deriv_den_ff;
      max_speed_in      = max_speed_ff;
      line_threshold_in = line_threshold_ff;
      speed_factor_in   = speed_factor_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PROP_NUM:       prop_num_in       = csr_wdata[GAIN_W-1:0];
            CSR_PROP_DEN:       prop_den_in       = csr_wdata[GAIN_W-1:0];
            CSR_DERIV_NUM:      deriv_num_in      = csr_wdata[GAIN_W-1:0];
            CSR_DERIV_DEN:      deriv_den_in      = csr_wdata[GAIN_W-1:0];
            CSR_MAX_SPEED:      max_speed_in      = csr_wdata[SPEED_CFG_W-1:0];
            CSR_LINE_THRESHOLD: line_threshold_in = csr_wdata[SENSOR_W-1:0];
            CSR_SPEED_FACTOR:   speed_factor_in   = csr_wdata[SPEED_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // frame sums
   assign sens[0] = req_ff.sensor_0;
   assign sens[1] = req_ff.sensor_1;
   assign sens[2] = req_ff.sensor_2;
   assign sens[3] = req_ff.sensor_3;
   assign sens[4] = req_ff.sensor_4;

   always_comb begin
      sum_v   = '0;
      sum_w   = '0;
      any_hit = 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         sum_v = sum_v + VSUM_W'(sens[i]);
         sum_w = sum_w + WIDX_W'(sens[i]) * WIDX_W'(i);
         if (sens[i] > line_threshold_ff) begin
            any_hit = 1'b1;
         end
      end
   end

   assign wsum      = WSUM_W'(widx_ff) * WSUM_W'(WEIGHT_SCALE);
   assign err_now   = $signed(ERR_W'(pos_ff)) - $signed(ERR_W'(CENTRE));
   assign ediff_now = err_now - prev_err_ff;
   assign q_mag     = div_quo[MAG_W-1:0];
   assign qs        = sign_ff ? -$signed(TERM_W'(q_mag)) : $signed(TERM_W'(q_mag));
   assign lv        = $signed(WHEEL_W'(max_speed_ff)) + WHEEL_W'(diff_ff);
   assign rv        = $signed(WHEEL_W'(max_speed_ff)) - WHEEL_W'(diff_ff);
   assign lprod     = PROD_W'(lclamp_ff) * PROD_W'(speed_factor_ff);
   assign rprod     = PROD_W'(rclamp_ff) * PROD_W'(speed_factor_ff);
   assign emit_go   = (uc_word.op == OP_EMIT) && step_go;

   // datapath control
   always_comb begin
      req_in      = req_ff;
      vsum_in     = vsum_ff;
      widx_in     = widx_ff;
      found_in    = found_ff;
      prod_in     = prod_ff;
      dvs_in      = dvs_ff;
      sign_in     = sign_ff;
      pos_in      = pos_ff;
      prev_err_in = prev_err_ff;
      err_in      = err_ff;
      ediff_in    = ediff_ff;
      pterm_in    = pterm_ff;
      diff_in     = diff_ff;
      lclamp_in   = lclamp_ff;
      rclamp_in   = rclamp_ff;
      rsp_data_in = rsp_data_ff;
      div_start   = 1'b0;
      case (uc_word.op)
         OP_CAPTURE: begin
            if (step_go) begin
               req_in = req_data;
            end
         end
         OP_SUM: begin
            vsum_in  = sum_v;
            widx_in  = sum_w;
            found_in = any_hit;
         end
         OP_WMUL: begin
            prod_in = DVD_W'(wsum);
            dvs_in  = vsum_ff;
         end
         OP_DIV: begin
            div_start = 1'b1;
         end
         OP_LOAD_POS: begin
            if (step_go) begin
               pos_in = div_quo[POS_W-1:0];
            end
         end
         OP_ERR: begin
            err_in      = err_now;
            ediff_in    = ediff_now;
            prev_err_in = err_now;
         end
         OP_PMUL: begin
            prod_in = DVD_W'(MAG_W'(mag_of(err_ff)) * MAG_W'(prop_num_ff));
            sign_in = err_ff[ERR_W-1];
            dvs_in  = VSUM_W'(den_fix(prop_den_ff));
         end
         OP_LOAD_P: begin
            if (step_go) begin
               pterm_in = qs;
            end
         end
         OP_DMUL: begin
            prod_in = DVD_W'(MAG_W'(mag_of(ediff_ff)) * MAG_W'(deriv_num_ff));
            sign_in = ediff_ff[ERR_W-1];
            dvs_in  = VSUM_W'(den_fix(deriv_den_ff));
         end
         OP_LOAD_D: begin
            if (step_go) begin
               diff_in = pterm_ff + qs;
            end
         end
         OP_CLAMP: begin
            lclamp_in = clamp_speed(lv, max_speed_ff);
            rclamp_in = clamp_speed(rv, max_speed_ff);
         end
         OP_EMIT: begin
            if (step_go) begin
               rsp_data_in.left_speed  = lprod[Q_FRAC +: SPEED_W];
               rsp_data_in.right_speed = rprod[Q_FRAC +: SPEED_W];
               rsp_data_in.line_found  = found_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff             <= PC_IDLE;
         prop_num_ff       <= GAIN_W'(1);
         prop_den_ff       <= GAIN_W'(4);
         deriv_num_ff      <= GAIN_W'(6);
         deriv_den_ff      <= GAIN_W'(1);
         max_speed_ff      <= SPEED_CFG_W'(400);
         line_threshold_ff <= SENSOR_W'(200);
         speed_factor_ff   <= SPEED_CFG_W'(256);
         pos_ff            <= '0;
         prev_err_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pc_ff             <= pc_in;
         prop_num_ff       <= prop_num_in;
         prop_den_ff       <= prop_den_in;
         deriv_num_ff      <= deriv_num_in;
         deriv_den_ff      <= deriv_den_in;
         max_speed_ff      <= max_speed_in;
         line_threshold_ff <= line_threshold_in;
         speed_factor_ff   <= speed_factor_in;
         pos_ff            <= pos_in;
         prev_err_ff       <= prev_err_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      vsum_ff     <= vsum_in;
      widx_ff     <= widx_in;
      found_ff    <= found_in;
      prod_ff     <= prod_in;
      dvs_ff      <= dvs_in;
      sign_ff     <= sign_in;
      err_ff      <= err_in;
      ediff_ff    <= ediff_in;
      pterm_ff    <= pterm_in;
      diff_ff     <= diff_in;
      lclamp_ff   <= lclamp_in;
      rclamp_ff   <= rclamp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      (uc_word.op == OP_DIV) |-> !div_busy)
      else $error("divider started while busy");

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_EMIT)
      else $error("program counter outside program");

   a_accept_advances: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (pc_ff == PC_SUM))
      else $error("accepted transfer did not start the program");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(pc_ff) == PC_EMIT))
      else $error("result raised outside the emit step");

endmodule

### sv/lpps_div.sv
// ----------------------------------------------------------------------------
// lpps_div: iterative unsigned divider
// Restoring shift-subtract, STEP_BITS quotient bits per cycle, busy while active.
// ----------------------------------------------------------------------------
module lpps_div
   import lpps_pkg::*;
#(
   parameter int DVD_W     = 24,
   parameter int DVS_W     = VSUM_W,
   parameter int STEP_BITS = DIV_STEP_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEPS = (DVD_W + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_W = STEPS * STEP_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [PAD_W-1:0] dvd_ff, dvd_in;

   always_comb begin
      logic [DVS_W:0]   trial;
      logic [DVS_W-1:0] rem_v;
      logic [PAD_W-1:0] dvd_v;
      logic             qbit;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      rem_v   = rem_ff;
      dvd_v   = dvd_ff;
      for (int s = 0; s < STEP_BITS; s++) begin
         trial = {rem_v, dvd_v[PAD_W-1]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
            qbit  = 1'b1;
         end else begin
            qbit  = 1'b0;
         end
         rem_v = trial[DVS_W-1:0];
         dvd_v = {dvd_v[PAD_W-2:0], qbit};
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         rem_in  = '0;
         dvd_in  = PAD_W'(dividend);
      end else if (busy_ff) begin
         rem_in = rem_v;
         dvd_in = dvd_v;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff[DVD_W-1:0];

endmodule

### tb/tb_line_position_pd_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_position_pd_steering: self-checking bench for the line steering block
// Sends sensor frames through a directed table and random phases, across gain,
// speed and threshold settings, with sender gaps and receiver back-pressure.
// Each wheel speed transfer is checked against a PD steering predictor or a fixed table result.
// ----------------------------------------------------------------------------
module tb_line_position_pd_steering;
   import lpps_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int CENTER_POS    = (SENSOR_COUNT - 1) * WEIGHT_SCALE_DEF / 2;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 50;
   localparam int PHASE_COUNT   = 8;
   localparam int SETTLE_CYCLES = 48;

   typedef struct {
      req_type frame;
      bit      fixed;
      rsp_type result;
   } steer_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and steering state
   logic [GAIN_W-1:0]      prop_num_q     = 8'd1;
   logic [GAIN_W-1:0]      prop_den_q     = 8'd4;
   logic [GAIN_W-1:0]      deriv_num_q    = 8'd6;
   logic [GAIN_W-1:0]      deriv_den_q    = 8'd1;
   logic [SPEED_CFG_W-1:0] max_speed_q    = 10'd400;
   logic [SPEED_CFG_W-1:0] threshold_q    = 10'd200;
   logic [SPEED_CFG_W-1:0] speed_factor_q = 10'd256;
   int                     pos_held       = 0;
   longint                 err_last       = 0;

   rsp_type       speed_queue[$];
   steer_row_type directed_rows[$];
   int            error_count   = 0;
   int            send_idle_pct = 0;
   int            rcv_stall_pct = 0;
   bit            hold_request  = 1'b0;

   line_position_pd_steering DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic longint gain_term(input longint x, input logic [GAIN_W-1:0] num,
                                        input logic [GAIN_W-1:0] den);
      longint d;
      d = (den == '0) ? 64'sd1 : longint'(den);
      return (x * longint'(num)) / d;
   endfunction

   function automatic logic [SPEED_W-1:0] wheel_speed(input longint v);
      longint c;
      c = (v < 0) ? 64'sd0 : v;
      if (c > longint'(max_speed_q)) c = longint'(max_speed_q);
      return SPEED_W'((c * longint'(speed_factor_q)) >> Q_FRAC);
   endfunction

   function automatic rsp_type steer_predict(input req_type f);
      logic [SENSOR_W-1:0] s [SENSOR_COUNT];
      longint              wsum;
      longint              vsum;
      longint              err;
      longint              diff;
      bit                  found;
      rsp_type             r;
      s[0] = f.sensor_0;
      s[1] = f.sensor_1;
      s[2] = f.sensor_2;
      s[3] = f.sensor_3;
      s[4] = f.sensor_4;
      wsum  = 0;
      vsum  = 0;
      found = 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (s[i] > threshold_q) found = 1'b1;
         wsum += longint'(s[i]) * i * WEIGHT_SCALE_DEF;
         vsum += longint'(s[i]);
      end
      if (found && vsum != 0) pos_held = int'(wsum / vsum);
      err  = longint'(pos_held) - CENTER_POS;
      diff = gain_term(err, prop_num_q, prop_den_q)
           + gain_term(err - err_last, deriv_num_q, deriv_den_q);
      err_last = err;
      r.left_speed  = wheel_speed(longint'(max_speed_q) + diff);
      r.right_speed = wheel_speed(longint'(max_speed_q) - diff);
      r.line_found  = found;
      return r;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_PROP_NUM:       prop_num_q     = value[GAIN_W-1:0];
         CSR_PROP_DEN:       prop_den_q     = value[GAIN_W-1:0];
         CSR_DERIV_NUM:      deriv_num_q    = value[GAIN_W-1:0];
         CSR_DERIV_DEN:      deriv_den_q    = value[GAIN_W-1:0];
         CSR_MAX_SPEED:      max_speed_q    = value;
         CSR_LINE_THRESHOLD: threshold_q    = value;
         CSR_SPEED_FACTOR:   speed_factor_q = value;
         default: ;
      endcase
   endfunction

   function automatic req_type make_frame();
      int      v [SENSOR_COUNT];
      int      kind;
      int      lo;
      int      peak;
      int      center;
      int      spread;
      int      d;
      req_type f;
      kind   = int'($urandom_range(0, 9));
      lo     = int'(threshold_q) + 1;
      if (lo > SENSOR_MAX) lo = SENSOR_MAX;
      peak   = int'($urandom_range(SENSOR_MAX, lo));
      center = int'($urandom_range(0, SENSOR_COUNT - 1));
      spread = int'($urandom_range(20, 600));
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (kind <= 5) begin
            d = (i > center) ? i - center : center - i;
            v[i] = peak - d * spread + int'($urandom_range(0, 40));
            if (v[i] < 0) v[i] = 0;
            if (v[i] > SENSOR_MAX) v[i] = SENSOR_MAX;
         end else if (kind <= 7) begin
            v[i] = int'($urandom_range(0, threshold_q));
         end else if (kind == 8) begin
            v[i] = int'($urandom_range(0, SENSOR_MAX));
         end else begin
            v[i] = $urandom_range(0, 1) ? SENSOR_MAX : 0;
         end
      end
      f.sensor_0 = SENSOR_W'(v[0]);
      f.sensor_1 = SENSOR_W'(v[1]);
      f.sensor_2 = SENSOR_W'(v[2]);
      f.sensor_3 = SENSOR_W'(v[3]);
      f.sensor_4 = SENSOR_W'(v[4]);
      return f;
   endfunction

   task automatic add_row(input int s0, input int s1, input int s2, input int s3,
                          input int s4, input bit fixed, input int l, input int r,
                          input bit found);
      steer_row_type row;
      row.frame.sensor_0   = SENSOR_W'(s0);
      row.frame.sensor_1   = SENSOR_W'(s1);
      row.frame.sensor_2   = SENSOR_W'(s2);
      row.frame.sensor_3   = SENSOR_W'(s3);
      row.frame.sensor_4   = SENSOR_W'(s4);
      row.fixed            = fixed;
      row.result.left_speed  = SPEED_W'(l);
      row.result.right_speed = SPEED_W'(r);
      row.result.line_found  = found;
      directed_rows.push_back(row);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      apply_reg(idx, CSR_DATA_W'(value));
   endtask

   task automatic program_gains(input int pn, input int pd, input int dn, input int dd,
                                input int ms, input int lt, input int sf);
      csr_write(CSR_PROP_NUM, pn);
      csr_write(CSR_PROP_DEN, pd);
      csr_write(CSR_DERIV_NUM, dn);
      csr_write(CSR_DERIV_DEN, dd);
      csr_write(CSR_MAX_SPEED, ms);
      csr_write(CSR_LINE_THRESHOLD, lt);
      csr_write(CSR_SPEED_FACTOR, sf);
      csr_write(CSR_UNUSED, int'($urandom_range(0, 1023)));
      csr_we <= 1'b0;
   endtask

   task automatic push_frame(input req_type f, input bit fixed, input rsp_type fixed_rsp);
      rsp_type want;
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      do @(posedge clock); while (req_stall);
      want = steer_predict(f);
      if (fixed) want = fixed_rsp;
      speed_queue.push_back(want);
   endtask

   task automatic wait_drained();
      while (speed_queue.size() != 0) @(posedge clock);
   endtask

   // receiver: random stall, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= (int'($urandom_range(0, 99)) < rcv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_speeds
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (speed_queue.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transfer, expected none, actual left %0d right %0d line %0b",
                     $time, rsp_data.left_speed, rsp_data.right_speed,
                     rsp_data.line_found);
         end else begin
            want = speed_queue.pop_front();
            if (rsp_data.left_speed !== want.left_speed) begin
               error_count++;
               $display("%0t: left_speed expected %0d actual %0d",
                        $time, want.left_speed, rsp_data.left_speed);
            end
            if (rsp_data.right_speed !== want.right_speed) begin
               error_count++;
               $display("%0t: right_speed expected %0d actual %0d",
                        $time, want.right_speed, rsp_data.right_speed);
            end
            if (rsp_data.line_found !== want.line_found) begin
               error_count++;
               $display("%0t: line_found expected %0b actual %0b",
                        $time, want.line_found, rsp_data.line_found);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int sel;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset gains: kp 1/4, kd 6/1, max speed 400, threshold 200, unity factor
      add_row(0, 0, 0, 0, 0,                1'b1, 0, 400, 1'b0);
      add_row(1023, 1023, 1023, 1023, 1023, 1'b1, 400, 0, 1'b1);
      add_row(1023, 1023, 1023, 1023, 1023, 1'b1, 400, 400, 1'b1);
      add_row(0, 0, 0, 0, 1023,             1'b1, 400, 0, 1'b1);
      add_row(1023, 0, 0, 0, 0,             1'b1, 0, 400, 1'b1);
      add_row(0, 0, 200, 0, 0,              1'b1, 0, 400, 1'b0);
      add_row(0, 0, 201, 0, 0,              1'b1, 400, 0, 1'b1);
      add_row(0, 0, 201, 0, 0,              1'b1, 400, 400, 1'b1);
      add_row(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 1'b0, 0, 0, 1'b0);
      add_row(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 1'b0, 0, 0, 1'b0);
      add_row(0, 100, 900, 150, 0,          1'b0, 0, 0, 1'b0);
      add_row(0, 0, 1000, 10, 0,            1'b0, 0, 0, 1'b0);
      add_row(50, 50, 50, 50, 50,           1'b0, 0, 0, 1'b0);
      add_row(0, 0, 0, 300, 600,            1'b0, 0, 0, 1'b0);
      add_row(600, 300, 0, 0, 0,            1'b0, 0, 0, 1'b0);
      add_row(0, 0, 1000, 0, 0,             1'b0, 0, 0, 1'b0);
      foreach (directed_rows[k])
         push_frame(directed_rows[k].frame, directed_rows[k].fixed, directed_rows[k].result);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (p == 0)
            program_gains(0, 0, 0, 0, 0, 0, 0);
         else if (p == 1)
            program_gains(1, 0, 1, 0, 1023, 0, 1023);
         else if (p == 2)
            program_gains(255, 255, 255, 255, 1023, 1023, 1023);
         else if (p == PHASE_COUNT - 1)
            program_gains(1, 4, 6, 1, 400, 200, 256);
         else
            program_gains(int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                          int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                          int'($urandom_range(0, 1023)), int'($urandom_range(0, 700)),
                          int'($urandom_range(0, 1023)));
         sel = p % 4;
         send_idle_pct = (sel == 1) ? 88 : (sel == 3) ? 14 : 0;
         rcv_stall_pct = (sel == 2) ? 88 : (sel == 3) ? 14 : 0;
         if (p == 2) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               wait_drained();
            end
            push_frame(make_frame(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && speed_queue.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
sv/lpps_pkg.sv
sv/lpps_div.sv
sv/line_position_pd_steering.sv
tb/tb_line_position_pd_steering.sv
